// ===== rtl/lmsd_pkg.sv =====
package lmsd_pkg;

    // Lanes: one per pixel of a write transaction, column c lives in lane c % LANES
    localparam int LANES   = 4;
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 3;
    localparam int GROUP_W = 3;
    localparam int BITS_W  = 32;
    localparam int BIDX_W  = $clog2(BITS_W);
    localparam int FRAME_W = 32;

    // Transaction kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Per-lane memory commands from the scan controller
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
    } lane_ctl_t;

    // Per-lane modulator result, valid in the cycle after a scan read
    typedef struct packed {
        logic valid;
        logic carry;
    } lane_res_t;

endpackage

// ===== rtl/led_matrix_sigma_delta_scan.sv =====
// Channel  Handshake                Fields
// in       in_valid / in_stall      kind, row_index, column_group, pix0..pix3
// out      out_valid / out_stall    row_select, column_bits, vsync, frame_number
//
// A write transaction completes as it is accepted; a visible tick runs SCAN, DRAIN and FINISH
// (four lanes sweep one column group per cycle through a registered read).
// A dark tick goes straight to FINISH. One transaction is in work at a time.
// After reset a clearing pass over all ROWS * ceil(COLUMNS/4) addresses zeroes both stores;
// in_stall stays high during it.
// A finished tick waits in the output register; the block accepts the next input
// while that result is stalled, and holds a new tick result until the slot frees.
module led_matrix_sigma_delta_scan
    import lmsd_pkg::*;
#(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 7
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [ROW_W-1:0]   row_index,
    input  logic [GROUP_W-1:0] column_group,
    input  logic [PIX_W-1:0]   pix0,
    input  logic [PIX_W-1:0]   pix1,
    input  logic [PIX_W-1:0]   pix2,
    input  logic [PIX_W-1:0]   pix3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ROW_W-1:0]   row_select,
    output logic [BITS_W-1:0]  column_bits,
    output logic               vsync,
    output logic [FRAME_W-1:0] frame_number
);

    localparam int GROUPS = (COLUMNS + LANES - 1) / LANES;
    localparam int DEPTH  = ROWS * GROUPS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [GW-1:0]      scan_grp_reg;
    logic [GW-1:0]      grp_q_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               dark_reg;
    logic               out_valid_reg;
    logic [ROW_W-1:0]   row_select_reg;
    logic [BITS_W-1:0]  column_bits_reg;
    logic               vsync_reg;
    logic [FRAME_W-1:0] frame_number_reg;

    logic               accept_in;
    logic               out_free;
    logic               merge_start;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      scan_addr;
    logic [AW-1:0]      lane_addr;
    logic [LANES-1:0]   lane_on;
    logic [PIX_W-1:0]   pix_arr [LANES];
    lane_ctl_t          lane_ctl [LANES];
    lane_res_t          lane_res [LANES];
    logic [BITS_W-1:0]  merge_bits;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept_in   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign merge_start = accept_in && (kind == KIND_TICK);

    assign pix_arr[0] = pix0;
    assign pix_arr[1] = pix1;
    assign pix_arr[2] = pix2;
    assign pix_arr[3] = pix3;

    assign wr_addr   = AW'(int'(row_index) * GROUPS + int'(column_group));
    assign scan_addr = AW'(int'(cur_row_reg) * GROUPS + int'(scan_grp_reg));

    // Enable only lanes whose column exists
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_on[l] = (int'(column_group) * LANES + l) < COLUMNS;
        end
    end

    // Drive lane commands and the shared address
    always_comb
    begin
        lane_addr = clr_addr_reg;
        for (int l = 0; l < LANES; l++)
        begin
            lane_ctl[l] = '0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    lane_ctl[l].clear = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept_in && kind == KIND_WRITE && row_index < ROW_W'(ROWS))
                begin
                    lane_addr = wr_addr;
                    for (int l = 0; l < LANES; l++)
                    begin
                        lane_ctl[l].load = lane_on[l];
                    end
                end
            end
            S_SCAN:
            begin
                lane_addr = scan_addr;
                for (int l = 0; l < LANES; l++)
                begin
                    lane_ctl[l].scan = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        lmsd_lane #(
            .DEPTH(DEPTH),
            .AW   (AW)
        ) u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (lane_ctl[l]),
            .addr (lane_addr),
            .wdata(pix_arr[l]),
            .res  (lane_res[l])
        );
    end

    lmsd_merge #(
        .GW(GW)
    ) u_merge (
        .clk  (clk),
        .start(merge_start),
        .res  (lane_res),
        .grp  (grp_q_reg),
        .bits (merge_bits)
    );

    // Scan sequencer, row and frame counters, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            scan_grp_reg     <= '0;
            grp_q_reg        <= '0;
            cur_row_reg      <= '0;
            frame_reg        <= '0;
            dark_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            row_select_reg   <= '0;
            column_bits_reg  <= '0;
            vsync_reg        <= 1'b0;
            frame_number_reg <= '0;
        end
        else
        begin
            // Load a finished tick into the slot, or drop the result once taken
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (accept_in && kind == KIND_TICK)
                    begin
                        if (cur_row_reg < ROW_W'(ROWS))
                        begin
                            dark_reg     <= 1'b0;
                            scan_grp_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                        else
                        begin
                            dark_reg  <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SCAN:
                begin
                    grp_q_reg <= scan_grp_reg;
                    if (scan_grp_reg == GW'(GROUPS - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        scan_grp_reg <= scan_grp_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (dark_reg)
                        begin
                            row_select_reg   <= '0;
                            column_bits_reg  <= '0;
                            vsync_reg        <= 1'b1;
                            frame_number_reg <= frame_reg;
                            frame_reg        <= frame_reg + 1'b1;
                            cur_row_reg      <= '0;
                        end
                        else
                        begin
                            row_select_reg   <= cur_row_reg + 1'b1;
                            column_bits_reg  <= merge_bits;
                            vsync_reg        <= 1'b0;
                            frame_number_reg <= '0;
                            cur_row_reg      <= cur_row_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_select   = row_select_reg;
    assign column_bits  = column_bits_reg;
    assign vsync        = vsync_reg;
    assign frame_number = frame_number_reg;

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && kind == KIND_TICK |=> in_stall)
        else $error("tick transaction did not hold off the input");

    a_dark_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && vsync_reg |-> row_select_reg == '0 && column_bits_reg == '0)
        else $error("vsync result is not blank");

    a_dark_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && vsync_reg |-> cur_row_reg == '0)
        else $error("row counter not restarted after vsync");

    a_visible_sel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && !dark_reg && out_free |=> row_select_reg != '0)
        else $error("visible tick reported blank row select");

endmodule

// ===== rtl/lmsd_lane.sv =====
module lmsd_lane
    import lmsd_pkg::*;
#(
    parameter int DEPTH = 56,
    parameter int AW    = 6
)(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctl_t        ctl,
    input  logic [AW-1:0]    addr,
    input  logic [PIX_W-1:0] wdata,
    output lane_res_t        res
);

    logic [PIX_W-1:0] bright_mem [DEPTH];
    logic [PIX_W-1:0] acc_mem [DEPTH];

    logic [PIX_W-1:0] bright_q_reg;
    logic [PIX_W-1:0] acc_q_reg;
    logic [AW-1:0]    addr_q_reg;
    logic             scan_q_reg;
    logic [PIX_W:0]   sum;

    // Brightness store: clear sweep or pixel load, registered read for scan
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            bright_mem[addr] <= '0;
        end
        else if (ctl.load)
        begin
            bright_mem[addr] <= wdata;
        end
        if (ctl.scan)
        begin
            bright_q_reg <= bright_mem[addr];
            acc_q_reg    <= acc_mem[addr];
            addr_q_reg   <= addr;
        end
    end

    // Accumulator store: clear sweep or write back the wrapped sum
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_mem[addr] <= '0;
        end
        else if (scan_q_reg)
        begin
            acc_mem[addr_q_reg] <= sum[PIX_W-1:0];
        end
    end

    // Track which cycles carry read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_q_reg <= 1'b0;
        end
        else
        begin
            scan_q_reg <= ctl.scan;
        end
    end

    // First-order modulator: carry out of the add is the on bit
    assign sum       = {1'b0, acc_q_reg} + {1'b0, bright_q_reg};
    assign res.valid = scan_q_reg;
    assign res.carry = sum[PIX_W];

endmodule

// ===== rtl/lmsd_merge.sv =====
module lmsd_merge
    import lmsd_pkg::*;
#(
    parameter int GW = 3
)(
    input  logic              clk,
    input  logic              start,
    input  lane_res_t         res [LANES],
    input  logic [GW-1:0]     grp,
    output logic [BITS_W-1:0] bits
);

    logic [BITS_W-1:0] bits_reg;
    logic [BITS_W-1:0] bits_next;

    // Clear on a tick start, else drop each valid lane's on bit into its column position
    always_comb
    begin
        int col;
        col       = 0;
        bits_next = bits_reg;
        if (start)
        begin
            bits_next = '0;
        end
        else
        begin
            for (int l = 0; l < LANES; l++)
            begin
                col = int'(grp) * LANES + l;
                if (res[l].valid && col < BITS_W)
                begin
                    bits_next[col[BIDX_W-1:0]] = res[l].carry;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    assign bits = bits_reg;

endmodule

// ===== bench/lmsd_scan_checker.sv =====
module lmsd_scan_checker
    import lmsd_pkg::*;
#(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 7
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               kind,
    input  logic [ROW_W-1:0]   row_index,
    input  logic [GROUP_W-1:0] column_group,
    input  logic [PIX_W-1:0]   pix0,
    input  logic [PIX_W-1:0]   pix1,
    input  logic [PIX_W-1:0]   pix2,
    input  logic [PIX_W-1:0]   pix3,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [ROW_W-1:0]   row_select,
    input  logic [BITS_W-1:0]  column_bits,
    input  logic               vsync,
    input  logic [FRAME_W-1:0] frame_number,
    output int                 mismatches,
    output int                 pending,
    output int                 results_checked,
    output int                 frames_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROW_W-1:0]   row_select;
        logic [BITS_W-1:0]  column_bits;
        logic               vsync;
        logic [FRAME_W-1:0] frame_number;
    } scan_result_t;

    // Shadow copy of the pixel stores and scan position
    logic [PIX_W-1:0]   brightness [ROWS][COLUMNS];
    logic [PIX_W-1:0]   phase_acc  [ROWS][COLUMNS];
    logic [ROW_W-1:0]   scan_row;
    logic [FRAME_W-1:0] frame_count;

    scan_result_t results_due[$];
    int errs;
    int checked;
    int syncs;

    task automatic report_mismatch(input string field, input logic [BITS_W-1:0] got,
                                   input logic [BITS_W-1:0] want);
        errs++;
        if (errs <= 20)
            $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, field, got, want);
    endtask

    // Store up to four pixels; drop rows and columns past the matrix edge
    function automatic void load_pixels(input logic [ROW_W-1:0] r,
                                        input logic [GROUP_W-1:0] g,
                                        input logic [LANES*PIX_W-1:0] quad);
        int c;
        if (r >= ROWS)
            return;
        for (int k = 0; k < LANES; k++)
        begin
            c = g * LANES + k;
            if (c < COLUMNS)
                brightness[r][c] = quad[k*PIX_W +: PIX_W];
        end
    endfunction

    // Advance one scan tick: modulate a visible row, or emit the frame sync
    function automatic scan_result_t scan_tick();
        scan_result_t res;
        logic [PIX_W:0] sum;
        res = '0;
        if (scan_row < ROWS)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                sum = {1'b0, phase_acc[scan_row][c]} + {1'b0, brightness[scan_row][c]};
                phase_acc[scan_row][c] = sum[PIX_W-1:0];
                if (sum[PIX_W] && c < BITS_W)
                    res.column_bits[c] = 1'b1;
            end
            scan_row = scan_row + 1'b1;
            res.row_select = scan_row;
        end
        else
        begin
            res.vsync = 1'b1;
            res.frame_number = frame_count;
            frame_count = frame_count + 1'b1;
            scan_row = '0;
        end
        return res;
    endfunction

    // Compare each result transaction, then fold in each input transaction
    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t due;
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLUMNS; c++)
                begin
                    brightness[r][c] = '0;
                    phase_acc[r][c] = '0;
                end
            scan_row = '0;
            frame_count = '0;
            results_due.delete();
            errs = 0;
            checked = 0;
            syncs = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected result", column_bits, '0);
                else
                begin
                    due = results_due.pop_front();
                    if (row_select !== due.row_select)
                        report_mismatch("row_select", BITS_W'(row_select),
                                        BITS_W'(due.row_select));
                    if (column_bits !== due.column_bits)
                        report_mismatch("column_bits", column_bits, due.column_bits);
                    if (vsync !== due.vsync)
                        report_mismatch("vsync", BITS_W'(vsync), BITS_W'(due.vsync));
                    if (frame_number !== due.frame_number)
                        report_mismatch("frame_number", frame_number, due.frame_number);
                    checked++;
                    if (due.vsync)
                        syncs++;
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_TICK)
                    results_due.push_back(scan_tick());
                else
                    load_pixels(row_index, column_group, {pix3, pix2, pix1, pix0});
            end
        end
        pending <= results_due.size();
        mismatches <= errs;
        results_checked <= checked;
        frames_checked <= syncs;
    end

endmodule

// ===== bench/led_matrix_sigma_delta_scan_tb.sv =====
module led_matrix_sigma_delta_scan_tb;
    import lmsd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS        = 32;
    localparam int ROWS           = 7;
    localparam int RANDOM_ITEMS   = 1530;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 40;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               kind;
    logic [ROW_W-1:0]   row_index;
    logic [GROUP_W-1:0] column_group;
    logic [PIX_W-1:0]   pix0;
    logic [PIX_W-1:0]   pix1;
    logic [PIX_W-1:0]   pix2;
    logic [PIX_W-1:0]   pix3;
    logic               out_valid;
    logic               out_stall;
    logic [ROW_W-1:0]   row_select;
    logic [BITS_W-1:0]  column_bits;
    logic               vsync;
    logic [FRAME_W-1:0] frame_number;

    int mismatches;
    int pending;
    int results_checked;
    int frames_checked;

    int  items_sent = 0;
    int  writes_sent = 0;
    int  ticks_sent = 0;
    int  idle_cycles = 0;
    bit  holdoff_done = 1'b0;
    logic calm;

    // No idling on either side through this window of transactions
    assign calm = (items_sent >= 700) && (items_sent < 950);

    always #6 clk = ~clk;

    led_matrix_sigma_delta_scan #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .row_index(row_index),
        .column_group(column_group),
        .pix0(pix0),
        .pix1(pix1),
        .pix2(pix2),
        .pix3(pix3),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .row_select(row_select),
        .column_bits(column_bits),
        .vsync(vsync),
        .frame_number(frame_number)
    );

    lmsd_scan_checker #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) scan_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .row_index(row_index),
        .column_group(column_group),
        .pix0(pix0),
        .pix1(pix1),
        .pix2(pix2),
        .pix3(pix3),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .row_select(row_select),
        .column_bits(column_bits),
        .vsync(vsync),
        .frame_number(frame_number),
        .mismatches(mismatches),
        .pending(pending),
        .results_checked(results_checked),
        .frames_checked(frames_checked)
    );

    // Bias brightness toward full on, full off and half level
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            2: return 8'h80;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one transaction, with an occasional gap ahead of it, and wait for acceptance
    task automatic drive_item(input logic k, input logic [ROW_W-1:0] r,
                              input logic [GROUP_W-1:0] g,
                              input logic [PIX_W-1:0] p0, input logic [PIX_W-1:0] p1,
                              input logic [PIX_W-1:0] p2, input logic [PIX_W-1:0] p3);
        if (!calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        row_index <= r;
        column_group <= g;
        pix0 <= p0;
        pix1 <= p1;
        pix2 <= p2;
        pix3 <= p3;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (k == KIND_TICK)
            ticks_sent++;
        else
            writes_sent++;
    endtask

    // Scan tick with noise in the fields it ignores
    task automatic send_tick();
        drive_item(KIND_TICK, ROW_W'($urandom_range(0, 7)), GROUP_W'($urandom_range(0, 7)),
                   PIX_W'($urandom()), PIX_W'($urandom()),
                   PIX_W'($urandom()), PIX_W'($urandom()));
    endtask

    // Receiver: random stalls, plus one long hold-off so the block backs up
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!holdoff_done && items_sent >= 400)
            begin
                holdoff_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 9);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_WRITE;
        row_index <= '0;
        column_group <= '0;
        pix0 <= '0;
        pix1 <= '0;
        pix2 <= '0;
        pix3 <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme levels, both edge groups, an ignored row, two full frames
        drive_item(KIND_WRITE, 3'd0, 3'd0, 8'hFF, 8'h00, 8'h80, 8'h01);
        drive_item(KIND_WRITE, 3'd0, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drive_item(KIND_WRITE, 3'd6, 3'd3, 8'h80, 8'h7F, 8'hFF, 8'h01);
        drive_item(KIND_WRITE, 3'd6, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drive_item(KIND_WRITE, 3'd7, 3'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drive_item(KIND_WRITE, 3'd2, 3'd4, 8'hAA, 8'h55, 8'h00, 8'hFE);
        repeat (2 * (ROWS + 1)) send_tick();

        // Random: mostly ticks interleaved with pixel updates
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 55)
                send_tick();
            else
                drive_item(KIND_WRITE, ROW_W'($urandom_range(0, 7)),
                           GROUP_W'($urandom_range(0, 7)),
                           pick_level(), pick_level(), pick_level(), pick_level());
        end

        // Drain: wait out every expected result, then the tail latency
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d pixel writes and %0d scan ticks, with one long output hold-off",
                 writes_sent, ticks_sent);
        $display("compared %0d scan results field by field, %0d of them frame syncs",
                 results_checked, frames_checked);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lmsd_pkg.sv
rtl/lmsd_lane.sv
rtl/lmsd_merge.sv
rtl/led_matrix_sigma_delta_scan.sv
bench/lmsd_scan_checker.sv
bench/led_matrix_sigma_delta_scan_tb.sv
